// File: rtl/tsc_pkg.sv
// ----------------------------------------------------------------------------
// tsc_pkg
// shared types and constants of the threshold stream compaction block
// ----------------------------------------------------------------------------
package tsc_pkg;

  localparam int unsigned VALUE_W     = 16;
  localparam int unsigned POS_W       = 6;
  localparam int unsigned THRESH_W    = 24;
  localparam int unsigned COUNT_REG_W = 7;
  localparam int unsigned APB_DATA_W  = 32;
  localparam int unsigned APB_ADDR_W  = 3;

  localparam int unsigned MAX_ELEMENTS_DEF = 64;

  localparam logic [THRESH_W-1:0]    THRESH_RESET = '0;
  localparam logic [COUNT_REG_W-1:0] COUNT_RESET  = 7'd64;

  // register index, taken from paddr[2]
  typedef enum logic {
    REG_THRESHOLD = 1'b0,
    REG_COUNT     = 1'b1
  } reg_idx_e;

  typedef enum logic {
    ST_STREAM = 1'b0,
    ST_PAD    = 1'b1
  } ctrl_state_e;

  // controller to datapath
  typedef struct packed {
    logic take;  // accept the input transaction
    logic pad;   // load one padding result
  } tsc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_valid;   // output register holds a result
    logic close;       // current input closes the block
    logic pad_needed;  // padding follows the current input
    logic pad_last;    // next padding result is the final one
  } tsc_status_t;

endpackage

// File: rtl/tsc_in_if.sv
// ----------------------------------------------------------------------------
// tsc_in_if
// input element channel: valid, ready and one bfloat16 value
// ----------------------------------------------------------------------------
interface tsc_in_if
  import tsc_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

// File: rtl/tsc_out_if.sv
// ----------------------------------------------------------------------------
// tsc_out_if
// result channel: valid, ready and one compacted result
// ----------------------------------------------------------------------------
interface tsc_out_if
  import tsc_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value_res;
  logic [POS_W-1:0]   position;
  logic               is_padding;
  logic               last;

  modport source (output valid, output value_res, output position, output is_padding,
                  output last, input ready);
  modport sink   (input valid, input value_res, input position, input is_padding,
                  input last, output ready);
endinterface

// File: rtl/tsc_cfg.sv
// ----------------------------------------------------------------------------
// tsc_cfg
// apb register file: threshold and element count
// ----------------------------------------------------------------------------
module tsc_cfg
  import tsc_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [APB_ADDR_W-1:0]  paddr,
  input  logic [APB_DATA_W-1:0]  pwdata,
  output logic [APB_DATA_W-1:0]  prdata,
  output logic                   pready,
  output logic [THRESH_W-1:0]    threshold_o,
  output logic [COUNT_REG_W-1:0] count_o
);

  logic [THRESH_W-1:0]    thresh_q, thresh_d;
  logic [COUNT_REG_W-1:0] count_q, count_d;
  reg_idx_e               idx;
  logic                   wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[2]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    thresh_d = thresh_q;
    count_d  = count_q;
    if (wr_en) begin
      case (idx)
        REG_THRESHOLD: thresh_d = pwdata[THRESH_W-1:0];
        REG_COUNT:     count_d  = pwdata[COUNT_REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= THRESH_RESET;
      count_q  <= COUNT_RESET;
    end else begin
      thresh_q <= thresh_d;
      count_q  <= count_d;
    end
  end

  always_comb begin
    case (idx)
      REG_THRESHOLD: prdata = APB_DATA_W'(thresh_q);
      REG_COUNT:     prdata = APB_DATA_W'(count_q);
      default:       prdata = '0;
    endcase
  end

  assign threshold_o = thresh_q;
  assign count_o     = count_q;

endmodule

// File: rtl/tsc_dp.sv
// ----------------------------------------------------------------------------
// tsc_dp
// datapath: exact threshold compare, block counters, output register
// ----------------------------------------------------------------------------
module tsc_dp
  import tsc_pkg::*;
#(
  parameter int unsigned MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [THRESH_W-1:0]    threshold_i,
  input  logic [COUNT_REG_W-1:0] count_i,
  input  logic [VALUE_W-1:0]     value_i,
  input  logic                   out_ready_i,
  input  tsc_cmd_t               cmd_i,
  output tsc_status_t            status_o,
  output logic                   out_valid_o,
  output logic [VALUE_W-1:0]     value_res_o,
  output logic [POS_W-1:0]       position_o,
  output logic                   is_padding_o,
  output logic                   last_o
);

  localparam int unsigned CNT_W = $clog2(MAX_ELEMENTS + 1);
  localparam int unsigned Q_W   = 25;  // 255 << 17 fits
  localparam int unsigned CMP_W = 27;

  // ---- effective element count ----
  logic [CNT_W-1:0] cnt;

  always_comb begin
    if (count_i == '0) begin
      cnt = CNT_W'(1);
    end else if (32'(count_i) > MAX_ELEMENTS) begin
      cnt = CNT_W'(MAX_ELEMENTS);
    end else begin
      cnt = CNT_W'(count_i);
    end
  end

  // ---- exact bfloat16 >= threshold/256 ----
  logic                    v_neg;
  logic [7:0]              v_exp;
  logic [6:0]              v_man;
  logic [7:0]              sig;
  logic [7:0]              lsh_raw;
  logic [4:0]              lsh;
  logic [3:0]              rsh;
  logic [Q_W-1:0]          q;
  logic                    frac;
  logic signed [CMP_W-1:0] q_s;
  logic signed [CMP_W-1:0] t_s;
  logic signed [CMP_W-1:0] t_neg;
  logic                    survive;

  assign v_neg   = value_i[15];
  assign v_exp   = value_i[14:7];
  assign v_man   = value_i[6:0];
  assign sig     = {(v_exp != 8'd0), v_man};
  assign lsh_raw = v_exp - 8'd126;
  assign lsh     = (lsh_raw > 8'd17) ? 5'd17 : lsh_raw[4:0];
  assign rsh     = 4'(8'd126 - v_exp);

  always_comb begin
    if (v_exp >= 8'd126) begin
      q    = Q_W'(sig) << lsh;
      frac = 1'b0;
    end else if (v_exp >= 8'd118) begin
      // one to eight fraction bits shifted out
      q    = Q_W'(sig >> rsh);
      frac = (sig & ~(8'hFF << rsh)) != 8'd0;
    end else begin
      q    = '0;
      frac = sig != 8'd0;
    end
  end

  assign q_s   = $signed({2'b00, q});
  assign t_s   = CMP_W'($signed(threshold_i));
  assign t_neg = -t_s;

  always_comb begin
    if (v_exp == 8'hFF) begin
      survive = (v_man == 7'd0) && !v_neg;  // nan fails, +inf passes
    end else if (!v_neg) begin
      survive = q_s >= t_s;
    end else if (frac) begin
      survive = q_s < t_neg;
    end else begin
      survive = q_s <= t_neg;
    end
  end

  // ---- block counters ----
  logic [CNT_W-1:0] seen_q, seen_d;
  logic [CNT_W-1:0] surv_q, surv_d;
  logic [CNT_W-1:0] seen_next;
  logic [CNT_W-1:0] surv_after;
  logic             emit;
  logic             close;
  logic             pad_needed;
  logic             pad_last;

  assign seen_next  = seen_q + CNT_W'(1);
  assign close      = seen_next >= cnt;
  assign emit       = survive && (surv_q < cnt);
  assign surv_after = surv_q + CNT_W'(emit);
  assign pad_needed = surv_after < cnt;
  assign pad_last   = surv_q == (cnt - CNT_W'(1));

  // ---- output register ----
  logic               out_valid_q, out_valid_d;
  logic [VALUE_W-1:0] value_res_q, value_res_d;
  logic [POS_W-1:0]   position_q, position_d;
  logic               is_padding_q, is_padding_d;
  logic               last_q, last_d;

  always_comb begin
    seen_d       = seen_q;
    surv_d       = surv_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    value_res_d  = value_res_q;
    position_d   = position_q;
    is_padding_d = is_padding_q;
    last_d       = last_q;

    if (cmd_i.take) begin
      if (emit) begin
        out_valid_d  = 1'b1;
        value_res_d  = value_i;
        position_d   = POS_W'(surv_q);
        is_padding_d = 1'b0;
        last_d       = close && !pad_needed;
      end
      if (close) begin
        seen_d = '0;
        surv_d = pad_needed ? surv_after : '0;
      end else begin
        seen_d = seen_next;
        surv_d = surv_after;
      end
    end else if (cmd_i.pad) begin
      out_valid_d  = 1'b1;
      value_res_d  = '0;
      position_d   = POS_W'(surv_q);
      is_padding_d = 1'b1;
      last_d       = pad_last;
      surv_d       = pad_last ? '0 : surv_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q      <= '0;
      surv_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      seen_q      <= seen_d;
      surv_q      <= surv_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_res_q  <= value_res_d;
    position_q   <= position_d;
    is_padding_q <= is_padding_d;
    last_q       <= last_d;
  end

  assign status_o.out_valid  = out_valid_q;
  assign status_o.close      = close;
  assign status_o.pad_needed = pad_needed;
  assign status_o.pad_last   = pad_last;

  assign out_valid_o  = out_valid_q;
  assign value_res_o  = value_res_q;
  assign position_o   = position_q;
  assign is_padding_o = is_padding_q;
  assign last_o       = last_q;

endmodule

// File: rtl/tsc_ctrl.sv
// ----------------------------------------------------------------------------
// tsc_ctrl
// controller: streams elements, then drives tail padding
// ----------------------------------------------------------------------------
module tsc_ctrl
  import tsc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        out_ready_i,
  input  tsc_status_t status_i,
  output logic        in_ready_o,
  output tsc_cmd_t    cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        slot_free;

  // output register empty, or emptied in this cycle
  assign slot_free = !status_i.out_valid || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_STREAM: begin
        if (in_valid_i && slot_free && status_i.close && status_i.pad_needed) begin
          state_d = ST_PAD;
        end
      end
      ST_PAD: begin
        if (slot_free && status_i.pad_last) begin
          state_d = ST_STREAM;
        end
      end
      default: state_d = ST_STREAM;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      ST_STREAM: begin
        in_ready_o = slot_free;
        cmd_o.take = in_valid_i && slot_free;
      end
      ST_PAD: begin
        cmd_o.pad = slot_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_STREAM;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: rtl/threshold_stream_compaction.sv
// a surviving element is loaded into the output register at its transaction
// throughput: one element per cycle while the result side takes results; closing a block
//   with p padding results sends them from the single output register while input is held off
// reset: asynchronous, active low; threshold 0, element count 64, counters cleared,
//   output register empty
// ----------------------------------------------------------------------------
// threshold_stream_compaction
// keeps bfloat16 elements at or above a q.8 threshold, packs them to the
// front of the block and fills the tail with zero padding
// ----------------------------------------------------------------------------
module threshold_stream_compaction
  import tsc_pkg::*;
#(
  parameter int unsigned MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  tsc_in_if.sink                in_i,
  tsc_out_if.source             out_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  // configuration registers
  logic [THRESH_W-1:0]    threshold;
  logic [COUNT_REG_W-1:0] elem_count;

  // command and status between controller and datapath
  tsc_cmd_t    cmd;
  tsc_status_t status;

  tsc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .threshold_o (threshold),
    .count_o     (elem_count)
  );

  // controller: in stream state the input is open whenever the output
  // register can take a result; in pad state it issues padding results
  tsc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .in_ready_o  (in_i.ready),
    .cmd_o       (cmd)
  );

  // datapath: compare, elements seen and survivors emitted counters, the
  // survivor counter doubles as the padding slot index during the tail
  tsc_dp #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .threshold_i  (threshold),
    .count_i      (elem_count),
    .value_i      (in_i.value),
    .out_ready_i  (out_o.ready),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_valid_o  (out_o.valid),
    .value_res_o  (out_o.value_res),
    .position_o   (out_o.position),
    .is_padding_o (out_o.is_padding),
    .last_o       (out_o.last)
  );

endmodule

// File: bench/tb_threshold_stream_compaction.sv
// ----------------------------------------------------------------------------
// tb_threshold_stream_compaction
// self-checking bench for the threshold stream compaction block: a short
// table of hand-picked elements and register writes, then random blocks of
// bfloat16 elements under bursty input and a stalling result side, every
// result compared field by field to a table entry or the compaction model
// ----------------------------------------------------------------------------
module tb_threshold_stream_compaction;
  import tsc_pkg::*;

  // bfloat16 patterns used by the table and the random mix
  localparam logic [VALUE_W-1:0] BF_POS_ZERO  = 16'h0000;
  localparam logic [VALUE_W-1:0] BF_NEG_ZERO  = 16'h8000;
  localparam logic [VALUE_W-1:0] BF_ONE       = 16'h3F80;
  localparam logic [VALUE_W-1:0] BF_NEG_ONE   = 16'hBF80;
  localparam logic [VALUE_W-1:0] BF_Q8_LSB    = 16'h3B80;  // exactly 1/256
  localparam logic [VALUE_W-1:0] BF_MIN_SUB   = 16'h0001;
  localparam logic [VALUE_W-1:0] BF_NEG_SUB   = 16'h8001;
  localparam logic [VALUE_W-1:0] BF_POS_INF   = 16'h7F80;
  localparam logic [VALUE_W-1:0] BF_NEG_INF   = 16'hFF80;
  localparam logic [VALUE_W-1:0] BF_QNAN      = 16'h7FC0;
  localparam logic [VALUE_W-1:0] BF_NEG_NAN   = 16'hFFC1;
  localparam logic [VALUE_W-1:0] BF_ALL_ONES  = 16'hFFFF;
  localparam logic [VALUE_W-1:0] BF_MAX_FIN   = 16'h7F7F;
  localparam logic [VALUE_W-1:0] BF_POS_32768 = 16'h4700;
  localparam logic [VALUE_W-1:0] BF_POS_32640 = 16'h46FF;
  localparam logic [VALUE_W-1:0] BF_NEG_32768 = 16'hC700;
  localparam logic [VALUE_W-1:0] BF_NEG_33024 = 16'hC701;

  localparam logic [VALUE_W-1:0] SPECIALS [12] = '{
    BF_POS_ZERO, BF_NEG_ZERO, BF_MIN_SUB, BF_NEG_SUB, BF_POS_INF, BF_NEG_INF,
    BF_QNAN, BF_NEG_NAN, BF_ALL_ONES, BF_MAX_FIN, BF_ONE, BF_NEG_ONE
  };

  localparam logic [31:0] THR_MIN = 32'hFF80_0000;  // -32768.0, sign extended
  localparam logic [31:0] THR_MAX = 32'h007F_FFFF;  // just under 32768.0
  localparam logic [31:0] THR_LSB = 32'h0000_0001;  // 1/256
  localparam logic [31:0] THR_ZERO = 32'h0000_0000;

  localparam int unsigned RANDOM_ITEMS = 205;
  localparam int unsigned SETTLE_CYCLES = 4;   // output register plus margin
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned PRINT_CAP = 100;

  // one result transaction as seen on the output channel
  typedef struct packed {
    logic [VALUE_W-1:0] value_res;
    logic [POS_W-1:0]   position;
    logic               is_padding;
    logic               last;
  } slot_t;

  // per element: a hand-written result replaces the model's where present
  typedef struct packed {
    logic  checked;
    slot_t want;
  } typed_entry_t;

  typedef enum logic {
    ROW_WRITE = 1'b0,
    ROW_ELEM  = 1'b1
  } row_kind_e;

  // for element rows the element sits in data[15:0]
  typedef struct packed {
    row_kind_e   kind;
    reg_idx_e    idx;
    logic [31:0] data;
    logic        checked;
    slot_t       want;
  } dir_row_t;

  localparam slot_t NONE     = '0;
  localparam slot_t PAD_LAST = '{16'h0000, 6'd0, 1'b1, 1'b1};

  localparam int unsigned DIR_ROWS = 31;
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    // reset settings: threshold zero, blocks of 64, so no last mark yet
    '{ROW_ELEM,  REG_THRESHOLD, {16'h0, BF_ONE},       1'b1, '{BF_ONE, 6'd0, 1'b0, 1'b0}},
    '{ROW_ELEM,  REG_THRESHOLD, {16'h0, BF_NEG_ONE},   1'b0, NONE},
    // shrink the block mid-way: the closing element is dropped, no last mark
    '{ROW_WRITE, REG_COUNT,     32'd1,                 1'b0, NONE},
    '{ROW_ELEM,  REG_THRESHOLD, {16'h0, BF_ONE},       1'b0, NONE},
    // single element blocks: every element gives exactly one marked result
    '{ROW_ELEM,  REG_THRESHOLD, {16'h0, BF_ONE},       1'b1, '{BF_ONE, 6'd0, 1'b0, 1'b1}},
    '{ROW_ELEM,  REG_THRESHOLD, {16'h0, BF_NEG_ONE},   1'b1, PAD_LAST},
    '{ROW_ELEM,  REG_THRESHOLD, {16'h0, BF_NEG_ZERO},  1'b1,
      '{BF_NEG_ZERO, 6'd0, 1'b0, 1'b1}},
    '{ROW_ELEM,  REG_THRESHOLD, {16'h0, BF_POS_ZERO},  1'b1,
      '{BF_POS_ZERO, 6'd0, 1'b0, 1'b1}},
    '{ROW_ELEM,  REG_THRESHOLD, {16'h0, BF_QNAN},      1'b1, PAD_LAST},
    '{ROW_ELEM,  REG_THRESHOLD, {16'h0, BF_NEG_NAN},   1'b1, PAD_LAST},
    '{ROW_ELEM,  REG_THRESHOLD, {16'h0, BF_POS_INF},   1'b1,
      '{BF_POS_INF, 6'd0, 1'b0, 1'b1}},
    '{ROW_ELEM,  REG_THRESHOLD, {16'h0, BF_NEG_INF},   1'b1, PAD_LAST},
    '{ROW_ELEM,  REG_THRESHOLD, {16'h0, BF_MIN_SUB},   1'b1,
      '{BF_MIN_SUB, 6'd0, 1'b0, 1'b1}},
    '{ROW_ELEM,  REG_THRESHOLD, {16'h0, BF_NEG_SUB},   1'b1, PAD_LAST},
    // smallest positive threshold: subnormal falls short, 1/256 is equal
    '{ROW_WRITE, REG_THRESHOLD, THR_LSB,               1'b0, NONE},
    '{ROW_ELEM,  REG_THRESHOLD, {16'h0, BF_MIN_SUB},   1'b1, PAD_LAST},
    '{ROW_ELEM,  REG_THRESHOLD, {16'h0, BF_Q8_LSB},    1'b1,
      '{BF_Q8_LSB, 6'd0, 1'b0, 1'b1}},
    // most negative threshold
    '{ROW_WRITE, REG_THRESHOLD, THR_MIN,               1'b0, NONE},
    '{ROW_ELEM,  REG_THRESHOLD, {16'h0, BF_NEG_32768}, 1'b1,
      '{BF_NEG_32768, 6'd0, 1'b0, 1'b1}},
    '{ROW_ELEM,  REG_THRESHOLD, {16'h0, BF_NEG_33024}, 1'b1, PAD_LAST},
    // most positive threshold
    '{ROW_WRITE, REG_THRESHOLD, THR_MAX,               1'b0, NONE},
    '{ROW_ELEM,  REG_THRESHOLD, {16'h0, BF_POS_32768}, 1'b1,
      '{BF_POS_32768, 6'd0, 1'b0, 1'b1}},
    '{ROW_ELEM,  REG_THRESHOLD, {16'h0, BF_POS_32640}, 1'b1, PAD_LAST},
    '{ROW_ELEM,  REG_THRESHOLD, {16'h0, BF_MAX_FIN},   1'b1,
      '{BF_MAX_FIN, 6'd0, 1'b0, 1'b1}},
    // a count of zero behaves as one
    '{ROW_WRITE, REG_COUNT,     32'd0,                 1'b0, NONE},
    '{ROW_ELEM,  REG_THRESHOLD, {16'h0, BF_POS_INF},   1'b1,
      '{BF_POS_INF, 6'd0, 1'b0, 1'b1}},
    // three element block: one survivor then two padding results
    '{ROW_WRITE, REG_COUNT,     32'd3,                 1'b0, NONE},
    '{ROW_WRITE, REG_THRESHOLD, THR_ZERO,              1'b0, NONE},
    '{ROW_ELEM,  REG_THRESHOLD, {16'h0, BF_NEG_ONE},   1'b0, NONE},
    '{ROW_ELEM,  REG_THRESHOLD, {16'h0, BF_ONE},       1'b0, NONE},
    '{ROW_ELEM,  REG_THRESHOLD, {16'h0, BF_ALL_ONES},  1'b0, NONE}
  };

  logic clk_i;
  logic rst_ni;

  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  tsc_in_if  in_ch ();
  tsc_out_if out_ch ();

  threshold_stream_compaction u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_ch),
    .out_o   (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // model copy of the registers and block counters
  logic signed [THRESH_W-1:0] thresh_model = THRESH_RESET;
  logic [COUNT_REG_W-1:0]     count_model  = COUNT_RESET;
  int unsigned                seen_cnt     = 0;
  int unsigned                kept_cnt     = 0;

  slot_t        step_res[$];         // results of the element just modelled
  slot_t        pending_results[$];  // results still owed by the block
  typed_entry_t typed_results[$];    // one entry per element sent, in order

  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles   = 0;
  int unsigned rx_tick        = 0;

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  task automatic flag_mismatch(input string what);
    if (mismatch_count < PRINT_CAP) begin
      $display("%0t mismatch: %s", $time, what);
    end
    mismatch_count++;
  endtask

  // exact test of a bfloat16 value against thr/256; value*256 is split into
  // an integer part and a flag for any fraction below it
  function automatic bit at_or_above(input logic [VALUE_W-1:0] raw,
                                     input logic signed [THRESH_W-1:0] thr);
    logic [7:0] expo;
    longint     sig;
    longint     whole;
    longint     lim;
    int         sh;
    bit         part;
    lim  = thr;
    expo = raw[14:7];
    if (expo == 8'hFF) begin
      return (raw[6:0] == 7'd0) && !raw[15];
    end
    if (expo == 8'd0) begin
      sig = raw[6:0];
      sh  = -125;
    end else begin
      sig = {1'b1, raw[6:0]};
      sh  = int'(expo) - 126;
    end
    if (sh >= 0) begin
      if (sh > 17) sh = 17;  // far past any threshold already
      whole = sig << sh;
      part  = 1'b0;
    end else if (sh <= -9) begin
      whole = 0;
      part  = (sig != 0);
    end else begin
      whole = sig >> (-sh);
      part  = (sig & ((64'sd1 << (-sh)) - 1)) != 0;
    end
    if (!raw[15]) return whole >= lim;
    // negative: -(whole + fraction) >= lim
    if (part) return whole < -lim;
    return whole <= -lim;
  endfunction

  // one element into the compaction model, results left in step_res
  task automatic compact_element(input logic [VALUE_W-1:0] raw);
    int unsigned lim;
    int unsigned p;
    bit          closing;
    slot_t       s;
    step_res.delete();
    lim = count_model;
    if (lim == 0) lim = 1;
    if (lim > MAX_ELEMENTS_DEF) lim = MAX_ELEMENTS_DEF;
    seen_cnt = seen_cnt + 1;
    closing  = (seen_cnt >= lim);
    // a survivor past a shrunken count is dropped
    if (at_or_above(raw, thresh_model) && kept_cnt < lim) begin
      s = '{raw, POS_W'(kept_cnt), 1'b0, closing && (kept_cnt + 1 == lim)};
      step_res.push_back(s);
      kept_cnt++;
    end
    if (closing) begin
      for (p = kept_cnt; p < lim; p++) begin
        s = '{16'h0000, POS_W'(p), 1'b1, p == lim - 1};
        step_res.push_back(s);
      end
      seen_cnt = 0;
      kept_cnt = 0;
    end
  endtask

  // both channels sampled at the edge, inputs first so that expectations
  // are in place before any result of the same edge is looked at
  typed_entry_t got_entry;
  slot_t        got;
  slot_t        want;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready) begin
        compact_element(in_ch.value);
        got_entry = (typed_results.size() != 0) ? typed_results.pop_front() : '0;
        if (got_entry.checked) begin
          pending_results.push_back(got_entry.want);
        end else begin
          foreach (step_res[k]) pending_results.push_back(step_res[k]);
        end
      end
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.value_res, out_ch.position, out_ch.is_padding, out_ch.last};
        if (pending_results.size() == 0) begin
          flag_mismatch($sformatf("unexpected result %h pos %0d", got.value_res,
                                  got.position));
        end else begin
          want = pending_results.pop_front();
          if (got.value_res !== want.value_res)
            flag_mismatch($sformatf("value_res %h, wanted %h", got.value_res,
                                    want.value_res));
          if (got.position !== want.position)
            flag_mismatch($sformatf("position %0d, wanted %0d", got.position,
                                    want.position));
          if (got.is_padding !== want.is_padding)
            flag_mismatch($sformatf("is_padding %b, wanted %b", got.is_padding,
                                    want.is_padding));
          if (got.last !== want.last)
            flag_mismatch($sformatf("last %b, wanted %b at pos %0d", got.last,
                                    want.last, want.position));
        end
      end
    end
  end

  // watchdog on cycles without any transaction on either channel
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_threshold_stream_compaction: done, errors");
      $finish;
    end
  end

  // result side: a slowly rotating stall pattern, free-flowing, random,
  // periodic and heavily throttled in turn
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      rx_tick <= rx_tick + 1;
      case ((rx_tick >> 7) & 3)
        0: begin
          out_ch.ready <= 1'b1;
        end
        1: begin
          out_ch.ready <= ($urandom_range(0, 2) != 0);
        end
        2: begin
          out_ch.ready <= ((rx_tick & 3) != 3);
        end
        default: begin
          out_ch.ready <= ((rx_tick & 7) == 0) || ($urandom_range(0, 3) == 0);
        end
      endcase
    end
  end

  // one element transaction; valid stays up when no gap follows
  task automatic send_element(input logic [VALUE_W-1:0] v, input logic checked,
                              input slot_t want_slot, input int unsigned gap);
    typed_results.push_back('{checked, want_slot});
    in_ch.valid <= 1'b1;
    in_ch.value <= v;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // stop sending, let every owed result out, then let a dropped closing
  // element work its way through
  task automatic wait_idle();
    if (in_ch.valid) in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // register write followed by a read back of the same register
  task automatic write_reg(input reg_idx_e idx, input logic [31:0] data);
    logic [31:0] mask;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    pwrite  <= 1'b1;
    psel    <= 1'b1;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (idx == REG_THRESHOLD) begin
      thresh_model = data[THRESH_W-1:0];
    end else begin
      count_model = data[COUNT_REG_W-1:0];
    end
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    mask = (idx == REG_THRESHOLD) ? 32'h00FF_FFFF : 32'h0000_007F;
    if ((prdata & mask) !== (data & mask))
      flag_mismatch($sformatf("register %0d reads %h, wrote %h", idx, prdata, data));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // random element: mostly magnitudes around the threshold range, plus
  // raw patterns, specials and tiny values
  function automatic logic [VALUE_W-1:0] pick_value();
    logic       sgn;
    logic [6:0] man;
    sgn = $urandom_range(0, 1);
    man = $urandom_range(0, 127);
    case ($urandom_range(0, 9))
      0, 1: return $urandom_range(0, 65535);
      2: return SPECIALS[$urandom_range(0, 11)];
      3: return {sgn, 8'($urandom_range(0, 8)), man};
      default: return {sgn, 8'($urandom_range(116, 143)), man};
    endcase
  endfunction

  function automatic logic [31:0] pick_threshold();
    case ($urandom_range(0, 7))
      0: return THR_MIN;
      1: return THR_MAX;
      2: return THR_ZERO;
      3: return 32'($signed($urandom_range(0, 64)) - 32) * 256;
      4, 5: return 32'($signed($urandom_range(0, 4095)) - 2048);
      default: return {{8{1'b0}}, 24'($urandom)} ^ {{8{1'b0}}, 24'h0};
    endcase
  endfunction

  initial begin : stimulus
    int unsigned r;
    int unsigned phase;
    int unsigned n;
    int unsigned i;
    int unsigned eff;
    int unsigned random_sent;
    int unsigned burst_left;
    int unsigned gap;
    logic [31:0] thr;
    logic [31:0] cnt;

    rst_ni      <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.value <= '0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // table part
    for (r = 0; r < DIR_ROWS; r++) begin
      if (DIRECTED[r].kind == ROW_WRITE) begin
        wait_idle();
        write_reg(DIRECTED[r].idx, DIRECTED[r].data);
        @(posedge clk_i);
      end else begin
        send_element(DIRECTED[r].data[VALUE_W-1:0], DIRECTED[r].checked,
                     DIRECTED[r].want, $urandom_range(0, 2));
      end
    end

    // random part: phases of one setting each, mostly whole blocks; a
    // partial block leaves the counters mid-way for the next setting
    random_sent = 0;
    burst_left  = 0;
    phase       = 0;
    while (random_sent < RANDOM_ITEMS) begin
      wait_idle();
      thr = pick_threshold();
      case (phase)
        0: cnt = MAX_ELEMENTS_DEF;
        2: cnt = 127;  // out of range, acts as the maximum
        default: begin
          case ($urandom_range(0, 5))
            0: cnt = 0;
            1: cnt = 1;
            default: cnt = $urandom_range(2, 12);
          endcase
        end
      endcase
      write_reg(REG_THRESHOLD, thr);
      @(posedge clk_i);
      write_reg(REG_COUNT, cnt);
      @(posedge clk_i);
      eff = (cnt == 0) ? 1 : ((cnt > MAX_ELEMENTS_DEF) ? MAX_ELEMENTS_DEF : cnt);
      n = (eff > 16) ? eff : eff * $urandom_range(1, 3);
      if (phase > 2 && $urandom_range(0, 4) == 0) n = $urandom_range(1, n);
      for (i = 0; i < n && random_sent < RANDOM_ITEMS; i++) begin
        if (burst_left == 0) begin
          burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 12);
          gap = $urandom_range(1, 8);
        end else begin
          gap = 0;
        end
        burst_left--;
        send_element(pick_value(), 1'b0, NONE, gap);
        random_sent++;
        // hold off until the block has caught up with every result
        if ((phase == 1 && i == n / 2) || $urandom_range(0, 49) == 0) begin
          wait_idle();
        end
      end
      phase++;
    end

    wait_idle();
    repeat (16) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("tb_threshold_stream_compaction: done, clean");
    end else begin
      $display("tb_threshold_stream_compaction: done, errors");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/tsc_pkg.sv
rtl/tsc_in_if.sv
rtl/tsc_out_if.sv
rtl/tsc_cfg.sv
rtl/tsc_dp.sv
rtl/tsc_ctrl.sv
rtl/threshold_stream_compaction.sv
bench/tb_threshold_stream_compaction.sv
